@@ hw/rtl/safs_pkg.sv @@
// ----------------------------------------------------------------------------
// safs_pkg: shared types and constants of the slot allocator
// Slot count, index and counter widths, operation and status codes, and the
// control group that drives the free-index stack.
// ----------------------------------------------------------------------------
`default_nettype none

package safs_pkg;

  localparam int unsigned SLOTS  = 128;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned DIN_W  = 16;
  localparam int unsigned DESC_W = 17;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_GET     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // At most one request to the free-index stack per accepted item, never both.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/safs_free_stack.sv @@
// ----------------------------------------------------------------------------
// safs_free_stack: LIFO of freed slot indices
// The entries live in a memory; the top entry is kept in a register that is
// refilled from the memory on every pop and set to the pushed index on a push.
// ----------------------------------------------------------------------------
`default_nettype none

module safs_free_stack (
  input  logic                          clk,
  input  logic                          rst,
  input  safs_pkg::stack_ctl_t          ctl,
  input  logic [safs_pkg::SLOT_W-1:0]   push_idx,
  output logic [safs_pkg::CNT_W-1:0]    count,
  output logic [safs_pkg::SLOT_W-1:0]   top
);

  logic [safs_pkg::SLOT_W-1:0] mem [safs_pkg::SLOTS];
  logic [safs_pkg::CNT_W-1:0]  count_m2;

  // Address of the entry that becomes the top after a pop.
  assign count_m2 = count - safs_pkg::CNT_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + safs_pkg::CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - safs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count[safs_pkg::SLOT_W-1:0]] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top <= push_idx;
    end else if (ctl.pop) begin
      top <= mem[count_m2[safs_pkg::SLOT_W-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/slot_allocator_free_stack_core.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_core: fixed-capacity handle allocator
// Create, destroy and get requests over 128 slots with a free-index stack.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while ready and returns exactly
// one result for each in the cycle after acceptance. All state is updated at
// the accepting edge, so a request always sees the effect of the one before
// it. The result sits in an output register; the input is ready whenever that
// register is empty or is being emptied in the same cycle, so a stalled
// output holds back exactly one item. Create reuses the most recently freed
// slot, otherwise the next never-used slot, and reports no free slot once all
// slots have been handed out and none is free. Destroy of a slot that is not
// active leaves everything unchanged. Destroy and get of an index at or above
// the high-water mark report an invalid index. The descriptor store and the
// free stack are memories without reset; no value read from an entry is used
// before it is written, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_allocator_free_stack_core (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [11:0] slot_index, [27:12] descriptor_in, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [6:0] slot_out, [23:7] descriptor_out, [24] active_out
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int unsigned SW = safs_pkg::SLOT_W;
  localparam int unsigned CW = safs_pkg::CNT_W;
  localparam int unsigned DW = safs_pkg::DESC_W;

  // Request fields.
  logic                        accept;
  safs_pkg::op_t               op;
  logic [safs_pkg::IDX_W-1:0]  slot_index;
  logic [safs_pkg::DIN_W-1:0]  descriptor_in;
  logic [SW-1:0]               idx;

  // Allocator state.
  logic [safs_pkg::SLOTS-1:0]  slot_in_use;
  logic [CW-1:0]               high_water;
  logic [DW-1:0]               desc_mem [safs_pkg::SLOTS];
  logic [DW-1:0]               desc_rd;

  // Free stack.
  safs_pkg::stack_ctl_t        stack_ctl;
  logic [CW-1:0]               free_count;
  logic [SW-1:0]               free_top;

  // Decoded request.
  logic                        in_range;
  logic                        stack_any;
  logic                        can_create;
  logic [SW-1:0]               new_slot;
  logic                        hw_inc;
  logic                        use_set;
  logic                        use_clr;
  logic [SW-1:0]               use_idx;
  logic                        desc_we;
  logic [SW-1:0]               desc_wa;
  logic [DW-1:0]               desc_wd;

  // Result fields before the output register.
  safs_pkg::status_t           status_next;
  logic [SW-1:0]               slot_next;
  logic [DW-1:0]               desc_next;
  logic                        active_next;
  logic                        use_mem_next;

  // Output register.
  safs_pkg::status_t           status;
  logic [SW-1:0]               slot_out;
  logic [DW-1:0]               desc_reg;
  logic                        active_out;
  logic                        use_mem;
  logic [DW-1:0]               descriptor_out;

  assign s_tready      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign op            = safs_pkg::op_t'(s_tuser);
  assign slot_index    = s_tdata[11:0];
  assign descriptor_in = s_tdata[27:12];
  assign idx           = slot_index[SW-1:0];

  // The high-water mark never exceeds the slot count, so this compare also
  // covers indices beyond the last slot.
  assign in_range   = slot_index < safs_pkg::IDX_W'(high_water);
  assign stack_any  = free_count != '0;
  assign can_create = stack_any || (high_water < CW'(safs_pkg::SLOTS));
  assign new_slot   = stack_any ? free_top : high_water[SW-1:0];

  always_comb begin
    status_next  = safs_pkg::ST_OK;
    slot_next    = idx;
    desc_next    = '0;
    active_next  = 1'b0;
    use_mem_next = 1'b0;
    stack_ctl    = '0;
    hw_inc       = 1'b0;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    use_idx      = idx;
    desc_we      = 1'b0;
    desc_wa      = idx;
    desc_wd      = '1;

    unique case (op)
      safs_pkg::OP_CREATE: begin
        if (can_create) begin
          slot_next     = new_slot;
          desc_next     = DW'(descriptor_in);
          active_next   = 1'b1;
          stack_ctl.pop = stack_any;
          hw_inc        = !stack_any;
          use_set       = 1'b1;
          use_idx       = new_slot;
          desc_we       = 1'b1;
          desc_wa       = new_slot;
          desc_wd       = DW'(descriptor_in);
        end else begin
          status_next = safs_pkg::ST_FULL;
          slot_next   = '0;
        end
      end
      safs_pkg::OP_DESTROY: begin
        if (!in_range) begin
          status_next = safs_pkg::ST_INVALID;
        end else if (slot_in_use[idx]) begin
          // Active slot: release it and hand its index to the free stack.
          desc_next      = '1;
          use_clr        = 1'b1;
          desc_we        = 1'b1;
          stack_ctl.push = free_count < CW'(safs_pkg::SLOTS);
        end else begin
          use_mem_next = 1'b1;
        end
      end
      safs_pkg::OP_GET: begin
        if (!in_range) begin
          status_next = safs_pkg::ST_INVALID;
        end else begin
          use_mem_next = 1'b1;
          active_next  = slot_in_use[idx];
        end
      end
      default: begin
        status_next = safs_pkg::ST_INVALID;
      end
    endcase

    if (!accept) begin
      stack_ctl = '0;
      hw_inc    = 1'b0;
      use_set   = 1'b0;
      use_clr   = 1'b0;
      desc_we   = 1'b0;
    end
  end

  safs_free_stack u_free_stack (
    .clk      (clk),
    .rst      (rst),
    .ctl      (stack_ctl),
    .push_idx (idx),
    .count    (free_count),
    .top      (free_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water  <= '0;
      slot_in_use <= '0;
    end else begin
      if (hw_inc) begin
        high_water <= high_water + CW'(1);
      end
      if (use_set) begin
        slot_in_use[use_idx] <= 1'b1;
      end else if (use_clr) begin
        slot_in_use[use_idx] <= 1'b0;
      end
    end
  end

  // Descriptor store: at most one write and one registered read per accepted item.
  // A request never uses the value read from an entry that it writes itself.
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= desc_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_rd <= desc_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      slot_out   <= slot_next;
      desc_reg   <= desc_next;
      active_out <= active_next;
      use_mem    <= use_mem_next;
    end
  end

  assign descriptor_out = use_mem ? desc_rd : desc_reg;

  assign m_tuser = status;
  assign m_tdata = {7'd0, active_out, descriptor_out, slot_out};

endmodule

`default_nettype wire

@@ hw/rtl/safs_checker.sv @@
// ----------------------------------------------------------------------------
// safs_checker: port-level checks of the slot allocator
// Watches both channels and checks result timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

module safs_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser
);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Every accepted request shows its result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after an accepted request");

  // A new request is taken only when the output register can take its result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request accepted over a stalled result");

  // A full report carries no slot, no descriptor and no active flag.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == safs_pkg::ST_FULL |-> m_tdata[24:0] == 25'd0)
    else $error("full result with non-zero payload");

  // A create either succeeds with an active slot or reports full.
  a_create: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == safs_pkg::OP_CREATE |=>
      (m_tuser == safs_pkg::ST_OK && m_tdata[24]) || m_tuser == safs_pkg::ST_FULL)
    else $error("create result is neither an active slot nor full");

endmodule

bind slot_allocator_free_stack_core safs_checker u_safs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/slot_allocator_free_stack_core_tb.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_core_tb: self-checking bench for the slot allocator
// Drives create, destroy and get requests over the request stream, keeps its
// own copy of the slot table, high-water mark and free stack, and compares
// every result item field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module slot_allocator_free_stack_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import safs_pkg::*;

  // Code that the block must treat as an invalid operation.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int STALL_LIMIT  = 4000;   // cycles with no item moving on either side
  localparam int REPORT_LINES = 40;     // mismatches printed before going quiet
  localparam int PHASE_ITEMS  = 350;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  typedef struct {
    status_t           status;
    logic [6:0]        slot;
    logic [DESC_W-1:0] descriptor;
    logic              active;
  } alloc_result_t;

  // Keeps a private copy of the allocator state, predicts the result of every
  // accepted request and checks the results in order of arrival.
  class slot_ledger;
    logic [DESC_W-1:0] descriptor_of [SLOTS];
    logic              in_use        [SLOTS];
    logic [SLOT_W-1:0] free_stack    [SLOTS];
    int                high_water;
    int                free_depth;
    int                errors;
    alloc_result_t     awaited[$];

    function new();
      foreach (in_use[i]) in_use[i] = 1'b0;
      high_water = 0;
      free_depth = 0;
      errors     = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(input string what);
      errors++;
      if (errors <= REPORT_LINES) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void note_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                               input logic [DIN_W-1:0] din);
      alloc_result_t     r;
      logic [SLOT_W-1:0] s;
      logic              got;
      r   = '{status: ST_INVALID, slot: idx[6:0], descriptor: '0, active: 1'b0};
      got = 1'b1;
      s   = '0;
      if (op == OP_CREATE) begin
        // Most recently freed slot first, then a never-used one.
        if (free_depth > 0) begin
          free_depth--;
          s = free_stack[free_depth];
        end else if (high_water < SLOTS) begin
          s = SLOT_W'(high_water);
          high_water++;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          descriptor_of[s] = {1'b0, din};
          in_use[s]        = 1'b1;
          r = '{status: ST_OK, slot: 7'(s), descriptor: {1'b0, din}, active: 1'b1};
        end else begin
          r = '{status: ST_FULL, slot: '0, descriptor: '0, active: 1'b0};
        end
      end else if ((op == OP_DESTROY || op == OP_GET) && idx < SLOTS && idx < high_water)
      begin
        // Destroying a slot that is already free changes nothing.
        if (op == OP_DESTROY && in_use[idx]) begin
          in_use[idx]        = 1'b0;
          descriptor_of[idx] = '1;
          free_stack[free_depth] = idx[SLOT_W-1:0];
          free_depth++;
        end
        r = '{status: ST_OK, slot: idx[6:0], descriptor: descriptor_of[idx],
              active: in_use[idx]};
      end
      awaited.push_back(r);
    endfunction

    task check_result(input logic [1:0] status, input logic [6:0] slot,
                      input logic [DESC_W-1:0] descriptor, input logic active);
      alloc_result_t r;
      if (awaited.size() == 0) begin
        report("result item arrived with no request outstanding");
      end else begin
        r = awaited.pop_front();
        if (status !== r.status)
          report($sformatf("status %0d, predicted %0d", status, r.status));
        if (slot !== r.slot)
          report($sformatf("slot_out %0d, predicted %0d", slot, r.slot));
        if (descriptor !== r.descriptor)
          report($sformatf("descriptor_out 0x%05h, predicted 0x%05h", descriptor,
                           r.descriptor));
        if (active !== r.active)
          report($sformatf("active_out %0b, predicted %0b", active, r.active));
      end
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [11:0] slot_index, [27:12] descriptor_in, rest zero
  logic [1:0]  s_tuser  = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [6:0] slot_out, [23:7] descriptor_out, [24] active_out
  logic [1:0]  m_tuser;         // [1:0] status

  int send_idle_pct = 30;
  int recv_idle_pct = 73;
  int quiet_cycles  = 0;

  slot_ledger ledger = new();

  slot_allocator_free_stack_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: every item taken at an edge is checked against the ledger,
  // and the ready for the next cycle is drawn afresh.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        ledger.check_result(m_tuser, m_tdata[6:0], m_tdata[23:7], m_tdata[24]);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one request, with a random number of idle cycles in front of it,
  // and returns once the block has taken it. The valid stays high on return,
  // so back-to-back requests leave no gap.
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DIN_W-1:0] din);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'd0, din, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ledger.note_request(op, idx, din);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Operation mix: filling runs the table up to the point where it is full,
  // draining frees slots so that creates later come off the free stack.
  function automatic logic [1:0] pick_op(input mix_t mix);
    int roll;
    int create_pct;
    int destroy_pct;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        create_pct  = 80;
        destroy_pct = 8;
      end
      MIX_DRAIN: begin
        create_pct  = 15;
        destroy_pct = 65;
      end
      default: begin
        create_pct  = 40;
        destroy_pct = 30;
      end
    endcase
    if (roll < create_pct) return OP_CREATE;
    if (roll < create_pct + destroy_pct) return OP_DESTROY;
    if (roll < 97) return OP_GET;
    return OP_UNUSED;
  endfunction

  // Mostly slots that have been handed out, sometimes ones never used, and
  // sometimes anything the 12-bit field can hold.
  function automatic logic [IDX_W-1:0] pick_index(input int hw);
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return IDX_W'($urandom_range(hw > 0 ? hw - 1 : 0));
    if (roll < 90) return IDX_W'($urandom_range(SLOTS - 1, hw < SLOTS ? hw : 0));
    return IDX_W'($urandom_range(4095));
  endfunction

  function automatic logic [DIN_W-1:0] pick_descriptor();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return DIN_W'($urandom_range(65535));
  endfunction

  task automatic run_mix(input mix_t mix, input int count);
    for (int n = 0; n < count; n++)
      send_item(pick_op(mix), pick_index(ledger.high_water), pick_descriptor());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: requests against an empty table, the first creates,
    // destroy of a freed slot, reuse of freed slots in last-in first-out
    // order, and indices beyond the table or beyond the high-water mark.
    send_item(OP_GET,     12'd0,    16'h0000);
    send_item(OP_DESTROY, 12'd0,    16'hFFFF);
    send_item(OP_UNUSED,  12'd4095, 16'hFFFF);
    send_item(OP_CREATE,  12'd4095, 16'h0000);
    send_item(OP_CREATE,  12'd0,    16'hFFFF);
    send_item(OP_CREATE,  12'd77,   16'h1234);
    send_item(OP_GET,     12'd4095, 16'h0000);
    send_item(OP_DESTROY, 12'd128,  16'h0000);
    send_item(OP_GET,     12'd3,    16'h0000);
    send_item(OP_GET,     12'd1,    16'h0000);
    send_item(OP_DESTROY, 12'd1,    16'h0000);
    send_item(OP_DESTROY, 12'd1,    16'h0000);
    send_item(OP_GET,     12'd1,    16'h0000);
    send_item(OP_DESTROY, 12'd0,    16'h0000);
    send_item(OP_CREATE,  12'd0,    16'hAAAA);
    send_item(OP_CREATE,  12'd0,    16'h5555);
    send_item(OP_CREATE,  12'd0,    16'h0001);
    send_item(OP_GET,     12'd0,    16'h0000);
    send_item(OP_UNUSED,  12'd0,    16'h0000);
    send_item(OP_GET,     12'd2,    16'h0000);

    // Three random phases with different back-pressure. Before each one the
    // sender holds off until every outstanding result has come back.
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_mix(MIX_FILL,     PHASE_ITEMS * 4 / 7);
      run_mix(MIX_DRAIN,    PHASE_ITEMS * 2 / 7);
      run_mix(MIX_BALANCED, PHASE_ITEMS / 7);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/safs_pkg.sv
hw/rtl/safs_free_stack.sv
hw/rtl/slot_allocator_free_stack_core.sv
hw/rtl/safs_checker.sv
tb/slot_allocator_free_stack_core_tb.sv
